// ===== sv/dla_pkg.sv =====
// Shared types, grid constants and helper functions for the DLA walker block.
package dla_pkg;

  // Grid geometry
  localparam int GRID_COLS = 600;
  localparam int GRID_ROWS = 400;
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int CELL_W    = $clog2(GRID_COLS * GRID_ROWS);
  localparam int SPAN_X    = GRID_COLS - 1;
  localparam int SPAN_Y    = GRID_ROWS - 1;
  localparam int PERIM     = 2 * (SPAN_X + SPAN_Y);
  localparam int SEED_X    = GRID_COLS / 2;
  localparam int SEED_Y    = GRID_ROWS / 2;

  // Port field widths
  localparam int IDX_W      = 18;
  localparam int RAND_W     = 32;
  localparam int STEP_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [STEP_W-1:0] MAX_STEPS_RESET = 16'd10000;

  // Constant-modulus reduction: byte residues summed, then reciprocal multiply
  localparam int MOD_W   = $clog2(PERIM + 1);
  localparam int VSUM_W  = MOD_W + 10;
  localparam int SHIFT   = VSUM_W + MOD_W;
  localparam int RECIP_W = SHIFT;

  localparam logic [63:0] RECIP_X = ((64'd1 << SHIFT) / SPAN_X) + 64'd1;
  localparam logic [63:0] RECIP_Y = ((64'd1 << SHIFT) / SPAN_Y) + 64'd1;
  localparam logic [63:0] RECIP_P = ((64'd1 << SHIFT) / PERIM) + 64'd1;

  localparam int WX1 = 256 % SPAN_X;
  localparam int WX2 = 65536 % SPAN_X;
  localparam int WX3 = 16777216 % SPAN_X;
  localparam int WY1 = 256 % SPAN_Y;
  localparam int WY2 = 65536 % SPAN_Y;
  localparam int WY3 = 16777216 % SPAN_Y;
  localparam int WP1 = 256 % PERIM;
  localparam int WP2 = 65536 % PERIM;
  localparam int WP3 = 16777216 % PERIM;

  // Result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic {
    CMD_SPAWN = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // Step direction; the same coding picks the border side of a spawn
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    EV_SPAWN   = 3'd0,
    EV_MOVE    = 3'd1,
    EV_STUCK   = 3'd2,
    EV_ESCAPE  = 3'd3,
    EV_TIMEOUT = 3'd4
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPAWN_MODE = 1'b0,
    REG_MAX_STEPS  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MOD_X     = 2'd0,
    MOD_Y     = 2'd1,
    MOD_PERIM = 2'd2
  } mod_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_MID,
    ST_RD_DOWN,
    ST_DECIDE,
    ST_TIMEOUT,
    ST_SPAWN
  } ctl_state_t;

  typedef struct packed {
    event_t           ev;
    logic             dest_valid;
    logic [IDX_W-1:0] dest_index;
    logic [IDX_W-1:0] src_index;
    logic             last;
  } res_t;

  typedef struct packed {
    logic                 en;
    logic                 we;
    logic [ROW_W-1:0]     addr;
    logic [GRID_COLS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic [CELL_W-1:0] idx;
  } spawn_pos_t;

  typedef struct packed {
    logic [MOD_W-1:0] w1;
    logic [MOD_W-1:0] w2;
    logic [MOD_W-1:0] w3;
  } weights_t;

  function automatic logic [MOD_W-1:0] mod_value(input mod_sel_t sel);
    unique case (sel)
      MOD_X:   return MOD_W'(SPAN_X);
      MOD_Y:   return MOD_W'(SPAN_Y);
      default: return MOD_W'(PERIM);
    endcase
  endfunction

  function automatic logic [RECIP_W-1:0] mod_recip(input mod_sel_t sel);
    unique case (sel)
      MOD_X:   return RECIP_W'(RECIP_X);
      MOD_Y:   return RECIP_W'(RECIP_Y);
      default: return RECIP_W'(RECIP_P);
    endcase
  endfunction

  // Residues of 2^8, 2^16 and 2^24 for the chosen modulus
  function automatic weights_t byte_weights(input mod_sel_t sel);
    weights_t w;
    unique case (sel)
      MOD_X:   w = '{w1: MOD_W'(WX1), w2: MOD_W'(WX2), w3: MOD_W'(WX3)};
      MOD_Y:   w = '{w1: MOD_W'(WY1), w2: MOD_W'(WY2), w3: MOD_W'(WY3)};
      default: w = '{w1: MOD_W'(WP1), w2: MOD_W'(WP2), w3: MOD_W'(WP3)};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/dla_occ_mem.sv =====
// Occupancy grid memory: one row of cells per word, with a clearing pass after reset.
module dla_occ_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  dla_pkg::mem_req_t             req,
  output logic [dla_pkg::GRID_COLS-1:0] rdata,
  output logic                          ready
);

  logic [dla_pkg::GRID_COLS-1:0] mem [dla_pkg::GRID_ROWS];

  logic                          clr_active;
  logic [dla_pkg::ROW_W-1:0]     clr_row;
  logic                          wr_en;
  logic [dla_pkg::ROW_W-1:0]     wr_addr;
  logic [dla_pkg::GRID_COLS-1:0] wr_data;
  logic [dla_pkg::GRID_COLS-1:0] seed_row;

  assign seed_row = {{(dla_pkg::GRID_COLS-1){1'b0}}, 1'b1} << dla_pkg::SEED_X;
  assign ready    = !clr_active;

  // Clearing sweep, one row per cycle; the seed row gets its center bit
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_row    <= '0;
    end else if (clr_active) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == dla_pkg::ROW_W'(dla_pkg::GRID_ROWS - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // Write port: sweep has priority, the controller waits for ready
  always_comb begin
    if (clr_active) begin
      wr_en   = 1'b1;
      wr_addr = clr_row;
      wr_data = (clr_row == dla_pkg::ROW_W'(dla_pkg::SEED_Y)) ? seed_row : '0;
    end else begin
      wr_en   = req.en && req.we;
      wr_addr = req.addr;
      wr_data = req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read: data is on rdata in the cycle after the request
  always_ff @(posedge clk) begin
    if (!clr_active && req.en && !req.we) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ===== sv/dla_spawn_map.sv =====
// Spawn position pipeline: constant-modulus reduction of a random word and border mapping.
module dla_spawn_map (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       mode,
  input  logic [dla_pkg::RAND_W-1:0] ra,
  input  logic [dla_pkg::RAND_W-1:0] rb,
  output logic                       done,
  output dla_pkg::spawn_pos_t        pos
);

  localparam int MW = dla_pkg::MOD_W;
  localparam int VW = dla_pkg::VSUM_W;
  localparam int RW = dla_pkg::RECIP_W;

  logic [4:0] vld;

  // stage 0 (combinational from the request)
  logic [dla_pkg::RAND_W-1:0] word;
  dla_pkg::dir_t              side0;
  dla_pkg::mod_sel_t          sel0;
  dla_pkg::weights_t          wts;
  logic [VW-1:0]              vsum0;

  // stage registers
  logic [VW-1:0]          v1, v2;
  dla_pkg::mod_sel_t      sel1, sel2;
  dla_pkg::dir_t          side1, side2, side3;
  logic                   mode1, mode2, mode3;
  logic [VW-1:0]          q2;
  logic [MW-1:0]          r3;
  logic [dla_pkg::COL_W-1:0] x4;
  logic [dla_pkg::ROW_W-1:0] y4;

  logic [VW+RW-1:0]       prod1;
  logic [VW+MW-1:0]       qm2;
  logic [VW-1:0]          rem2;
  logic [dla_pkg::COL_W-1:0] x3c;
  logic [dla_pkg::ROW_W-1:0] y3c;

  // Select word and modulus, sum byte residues
  always_comb begin
    side0 = dla_pkg::dir_t'(ra[1:0]);
    if (mode) begin
      word = ra;
      sel0 = dla_pkg::MOD_PERIM;
    end else begin
      word = rb;
      sel0 = (side0 == dla_pkg::DIR_UP || side0 == dla_pkg::DIR_DOWN) ?
             dla_pkg::MOD_X : dla_pkg::MOD_Y;
    end
    wts   = dla_pkg::byte_weights(sel0);
    vsum0 = VW'(word[7:0])
          + VW'(word[15:8])  * VW'(wts.w1)
          + VW'(word[23:16]) * VW'(wts.w2)
          + VW'(word[31:24]) * VW'(wts.w3);
  end

  // Quotient by reciprocal multiply, then remainder
  assign prod1 = {{RW{1'b0}}, v1} * {{VW{1'b0}}, dla_pkg::mod_recip(sel1)};
  assign qm2   = {{MW{1'b0}}, q2} * {{VW{1'b0}}, dla_pkg::mod_value(sel2)};
  assign rem2  = v2 - VW'(qm2);

  // Map the remainder onto the border
  always_comb begin
    x3c = '0;
    y3c = '0;
    if (!mode3) begin
      unique case (side3)
        dla_pkg::DIR_UP: begin
          x3c = dla_pkg::COL_W'(r3 + MW'(1));
          y3c = '0;
        end
        dla_pkg::DIR_RIGHT: begin
          x3c = dla_pkg::COL_W'(dla_pkg::SPAN_X);
          y3c = dla_pkg::ROW_W'(r3 + MW'(1));
        end
        dla_pkg::DIR_DOWN: begin
          x3c = dla_pkg::COL_W'(r3);
          y3c = dla_pkg::ROW_W'(dla_pkg::SPAN_Y);
        end
        default: begin
          x3c = '0;
          y3c = dla_pkg::ROW_W'(r3);
        end
      endcase
    end else if (r3 < MW'(dla_pkg::SPAN_X)) begin
      x3c = dla_pkg::COL_W'(r3 + MW'(1));
      y3c = '0;
    end else if (r3 < MW'(dla_pkg::SPAN_X + dla_pkg::SPAN_Y)) begin
      x3c = dla_pkg::COL_W'(dla_pkg::SPAN_X);
      y3c = dla_pkg::ROW_W'(r3 - MW'(dla_pkg::SPAN_X) + MW'(1));
    end else if (r3 < MW'(2 * dla_pkg::SPAN_X + dla_pkg::SPAN_Y)) begin
      x3c = dla_pkg::COL_W'(r3 - MW'(dla_pkg::SPAN_X + dla_pkg::SPAN_Y));
      y3c = dla_pkg::ROW_W'(dla_pkg::SPAN_Y);
    end else begin
      x3c = '0;
      y3c = dla_pkg::ROW_W'(r3 - MW'(2 * dla_pkg::SPAN_X + dla_pkg::SPAN_Y));
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    v1    <= vsum0;
    sel1  <= sel0;
    side1 <= side0;
    mode1 <= mode;

    q2    <= prod1[dla_pkg::SHIFT +: VW];
    v2    <= v1;
    sel2  <= sel1;
    side2 <= side1;
    mode2 <= mode1;

    r3    <= MW'(rem2);
    side3 <= side2;
    mode3 <= mode2;

    x4    <= x3c;
    y4    <= y3c;

    pos.x   <= x4;
    pos.y   <= y4;
    pos.idx <= dla_pkg::CELL_W'(dla_pkg::CELL_W'(y4) * dla_pkg::CELL_W'(dla_pkg::GRID_COLS))
             + dla_pkg::CELL_W'(x4);
  end

  assign done = vld[4];

endmodule

// ===== sv/dla_res_fifo.sv =====
// Result queue between the walker controller and the result channel.
module dla_res_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  dla_pkg::res_t                 push_data,
  input  logic                          pop_ready,
  output dla_pkg::res_t                 head,
  output logic                          head_valid,
  output logic [dla_pkg::RES_CNT_W-1:0] count
);

  dla_pkg::res_t slots [dla_pkg::RES_DEPTH];

  logic [dla_pkg::RES_PTR_W-1:0] wr_ptr;
  logic [dla_pkg::RES_PTR_W-1:0] rd_ptr;
  logic                          pop;

  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign pop        = head_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/dla_walker_step.sv =====
// Top level: diffusion-limited aggregation walker with an occupancy row memory.
//
// Request channel (cmd_valid/cmd_ready): command 0 spawns a walker on the grid
// border from rand_a/rand_b, command 1 moves the walker one cell in the
// direction given by rand_a[1:0]. One request is held in an input register,
// so the next request is taken while the current one is being worked on.
// Result channel (res_valid/res_ready): move deltas from a four-entry queue.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 spawn_mode,
// 1 max_steps); write only while the block is idle.
// A step takes three row reads and the decide state, which may write the row
// back, all on the one memory port; an escape is pushed as the request is taken,
// a timeout adds a timeout state, a spawn waits on the five-stage position pipeline.
// A result is written into the queue before it shows on the result port.
// Reset: the occupancy memory is swept row by row, leaving only the center
// cell set; one request may be accepted into the input register meanwhile,
// but none starts until the sweep is done.
// When the receiver stalls, results wait in the queue; a request starts only
// with room for two results, so requests back up into cmd_ready.
module dla_walker_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  logic                           command,
  input  logic [dla_pkg::RAND_W-1:0]     rand_a,
  input  logic [dla_pkg::RAND_W-1:0]     rand_b,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [2:0]                     event_res,
  output logic                           dest_valid,
  output logic [dla_pkg::IDX_W-1:0]      dest_index,
  output logic [dla_pkg::IDX_W-1:0]      src_index,
  output logic                           last_of_run,
  input  logic                           cfg_we,
  input  logic [dla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dla_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = dla_pkg::COL_W;
  localparam int YW = dla_pkg::ROW_W;
  localparam int IW = dla_pkg::CELL_W;

  dla_pkg::ctl_state_t state, state_next;

  // Input register
  logic                       buf_valid;
  dla_pkg::cmd_t              buf_cmd;
  logic [dla_pkg::RAND_W-1:0] buf_ra;
  logic [dla_pkg::RAND_W-1:0] buf_rb;
  logic                       take;

  // Configuration
  logic                       spawn_mode;
  logic [dla_pkg::STEP_W-1:0] max_steps;

  // Walker state
  logic [CW-1:0]              walker_x;
  logic [YW-1:0]              walker_y;
  logic [IW-1:0]              walker_idx;
  logic [dla_pkg::STEP_W-1:0] step_count;
  logic                       walker_active;

  // Step in flight
  logic [CW-1:0]                 nx;
  logic [YW-1:0]                 ny;
  logic [IW-1:0]                 nidx;
  logic                          has_up;
  logic                          has_down;
  logic                          up_bit;
  logic [dla_pkg::GRID_COLS-1:0] mid_row;

  // Move decode
  logic          off_c;
  logic [CW-1:0] nx_c;
  logic [YW-1:0] ny_c;
  logic [IW-1:0] nidx_c;

  // Neighbor check
  logic [CW-1:0]                 lcol;
  logic [CW-1:0]                 rcol;
  logic                          down_bit;
  logic                          stuck_c;
  logic                          timeout_c;
  logic [dla_pkg::GRID_COLS-1:0] set_mask;

  // Submodule links
  dla_pkg::mem_req_t             mem_req;
  logic [dla_pkg::GRID_COLS-1:0] mem_rdata;
  logic                          mem_ready;
  logic                          sp_start;
  logic                          sp_done;
  dla_pkg::spawn_pos_t           sp_pos;
  logic                          push;
  dla_pkg::res_t                 push_data;
  dla_pkg::res_t                 res_head;
  logic [dla_pkg::RES_CNT_W-1:0] fifo_count;

  dla_occ_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata),
    .ready (mem_ready)
  );

  dla_spawn_map u_spawn (
    .clk   (clk),
    .rst   (rst),
    .start (sp_start),
    .mode  (spawn_mode),
    .ra    (buf_ra),
    .rb    (buf_rb),
    .done  (sp_done),
    .pos   (sp_pos)
  );

  dla_res_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop_ready  (res_ready),
    .head       (res_head),
    .head_valid (res_valid),
    .count      (fifo_count)
  );

  assign event_res   = res_head.ev;
  assign dest_valid  = res_head.dest_valid;
  assign dest_index  = res_head.dest_index;
  assign src_index   = res_head.src_index;
  assign last_of_run = res_head.last;

  // Take a request when idle, memory swept, and room for two results
  assign take = (state == dla_pkg::ST_IDLE) && buf_valid && mem_ready &&
                (fifo_count <= dla_pkg::RES_CNT_W'(dla_pkg::RES_DEPTH - 2));
  assign cmd_ready = !buf_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      buf_valid <= 1'b1;
    end else if (take) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      buf_cmd <= dla_pkg::cmd_t'(command);
      buf_ra  <= rand_a;
      buf_rb  <= rand_b;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spawn_mode <= 1'b0;
      max_steps  <= dla_pkg::MAX_STEPS_RESET;
    end else if (cfg_we) begin
      unique case (dla_pkg::cfg_reg_t'(cfg_index))
        dla_pkg::REG_SPAWN_MODE: spawn_mode <= cfg_data[0];
        dla_pkg::REG_MAX_STEPS:  max_steps  <= cfg_data;
      endcase
    end
  end

  // Direction decode against the current walker position
  always_comb begin
    off_c  = 1'b0;
    nx_c   = walker_x;
    ny_c   = walker_y;
    nidx_c = walker_idx;
    unique case (dla_pkg::dir_t'(buf_ra[1:0]))
      dla_pkg::DIR_UP: begin
        off_c  = (walker_y == '0);
        ny_c   = walker_y - 1'b1;
        nidx_c = walker_idx - IW'(dla_pkg::GRID_COLS);
      end
      dla_pkg::DIR_RIGHT: begin
        off_c  = (walker_x == CW'(dla_pkg::SPAN_X));
        nx_c   = walker_x + 1'b1;
        nidx_c = walker_idx + 1'b1;
      end
      dla_pkg::DIR_DOWN: begin
        off_c  = (walker_y == YW'(dla_pkg::SPAN_Y));
        ny_c   = walker_y + 1'b1;
        nidx_c = walker_idx + IW'(dla_pkg::GRID_COLS);
      end
      default: begin
        off_c  = (walker_x == '0);
        nx_c   = walker_x - 1'b1;
        nidx_c = walker_idx - 1'b1;
      end
    endcase
  end

  // Neighbor bits: up latched, left/right from the middle row, down on the port
  assign lcol      = (nx == '0) ? nx : nx - 1'b1;
  assign rcol      = (nx == CW'(dla_pkg::SPAN_X)) ? nx : nx + 1'b1;
  assign down_bit  = has_down && mem_rdata[nx];
  assign stuck_c   = up_bit || down_bit ||
                     ((nx != '0) && mid_row[lcol]) ||
                     ((nx != CW'(dla_pkg::SPAN_X)) && mid_row[rcol]);
  assign timeout_c = (step_count >= max_steps);
  assign set_mask  = {{(dla_pkg::GRID_COLS-1){1'b0}}, 1'b1} << nx;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dla_pkg::ST_IDLE: begin
        if (take) begin
          if (buf_cmd == dla_pkg::CMD_SPAWN) begin
            state_next = dla_pkg::ST_SPAWN;
          end else if (walker_active && !off_c) begin
            state_next = dla_pkg::ST_RD_MID;
          end
        end
      end
      dla_pkg::ST_RD_MID:  state_next = dla_pkg::ST_RD_DOWN;
      dla_pkg::ST_RD_DOWN: state_next = dla_pkg::ST_DECIDE;
      dla_pkg::ST_DECIDE: begin
        if (!stuck_c && timeout_c) begin
          state_next = dla_pkg::ST_TIMEOUT;
        end else begin
          state_next = dla_pkg::ST_IDLE;
        end
      end
      dla_pkg::ST_TIMEOUT: state_next = dla_pkg::ST_IDLE;
      dla_pkg::ST_SPAWN: begin
        if (sp_done) begin
          state_next = dla_pkg::ST_IDLE;
        end
      end
      default: state_next = dla_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dla_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Controller outputs: memory request, result push, spawn start
  always_comb begin
    mem_req              = '0;
    sp_start             = 1'b0;
    push                 = 1'b0;
    push_data.ev         = dla_pkg::EV_MOVE;
    push_data.dest_valid = 1'b1;
    push_data.dest_index = dla_pkg::IDX_W'(nidx);
    push_data.src_index  = dla_pkg::IDX_W'(walker_idx);
    push_data.last       = 1'b1;
    unique case (state)
      dla_pkg::ST_IDLE: begin
        if (take) begin
          if (buf_cmd == dla_pkg::CMD_SPAWN) begin
            sp_start = 1'b1;
          end else if (walker_active && off_c) begin
            push                 = 1'b1;
            push_data.ev         = dla_pkg::EV_ESCAPE;
            push_data.dest_valid = 1'b0;
            push_data.dest_index = '0;
          end else if (walker_active) begin
            mem_req.en   = 1'b1;
            mem_req.addr = (ny_c != '0) ? ny_c - 1'b1 : ny_c;
          end
        end
      end
      dla_pkg::ST_RD_MID: begin
        mem_req.en   = 1'b1;
        mem_req.addr = ny;
      end
      dla_pkg::ST_RD_DOWN: begin
        mem_req.en   = 1'b1;
        mem_req.addr = has_down ? ny + 1'b1 : ny;
      end
      dla_pkg::ST_DECIDE: begin
        push = 1'b1;
        if (stuck_c) begin
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.addr  = ny;
          mem_req.wdata = mid_row | set_mask;
          push_data.ev  = dla_pkg::EV_STUCK;
        end else begin
          push_data.last = !timeout_c;
        end
      end
      dla_pkg::ST_TIMEOUT: begin
        push                 = 1'b1;
        push_data.ev         = dla_pkg::EV_TIMEOUT;
        push_data.dest_valid = 1'b0;
        push_data.dest_index = '0;
      end
      dla_pkg::ST_SPAWN: begin
        if (sp_done) begin
          push                 = 1'b1;
          push_data.ev         = dla_pkg::EV_SPAWN;
          push_data.dest_index = dla_pkg::IDX_W'(sp_pos.idx);
          push_data.src_index  = dla_pkg::IDX_W'(sp_pos.idx);
        end
      end
      default: ;
    endcase
  end

  // Walker state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      walker_x      <= '0;
      walker_y      <= '0;
      walker_idx    <= '0;
      step_count    <= '0;
      walker_active <= 1'b0;
    end else begin
      if (take && buf_cmd == dla_pkg::CMD_STEP && walker_active) begin
        if (step_count != '1) begin
          step_count <= step_count + 1'b1;
        end
        if (off_c) begin
          walker_active <= 1'b0;
        end
      end
      if (state == dla_pkg::ST_DECIDE) begin
        if (stuck_c) begin
          walker_active <= 1'b0;
        end else begin
          walker_x   <= nx;
          walker_y   <= ny;
          walker_idx <= nidx;
          if (timeout_c) begin
            walker_active <= 1'b0;
          end
        end
      end
      if (state == dla_pkg::ST_SPAWN && sp_done) begin
        walker_x      <= sp_pos.x;
        walker_y      <= sp_pos.y;
        walker_idx    <= sp_pos.idx;
        step_count    <= '0;
        walker_active <= 1'b1;
      end
    end
  end

  // Step datapath registers
  always_ff @(posedge clk) begin
    if (take) begin
      nx       <= nx_c;
      ny       <= ny_c;
      nidx     <= nidx_c;
      has_up   <= (ny_c != '0);
      has_down <= (ny_c != YW'(dla_pkg::SPAN_Y));
    end
    if (state == dla_pkg::ST_RD_MID) begin
      up_bit <= has_up && mem_rdata[nx];
    end
    if (state == dla_pkg::ST_RD_DOWN) begin
      mid_row <= mem_rdata;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count != dla_pkg::RES_CNT_W'(dla_pkg::RES_DEPTH)))
    else $error("result queue overflow");

  a_mem_after_sweep: assert property (@(posedge clk) disable iff (rst)
    mem_req.en |-> mem_ready)
    else $error("memory accessed during clearing sweep");

  a_write_on_stick: assert property (@(posedge clk) disable iff (rst)
    (mem_req.en && mem_req.we) |-> (state == dla_pkg::ST_DECIDE && stuck_c))
    else $error("occupancy written outside a stick");

  a_end_reported: assert property (@(posedge clk) disable iff (rst)
    $fell(walker_active) |-> $past(push))
    else $error("walker removed without a result");

  a_spawn_expected: assert property (@(posedge clk) disable iff (rst)
    sp_done |-> (state == dla_pkg::ST_SPAWN))
    else $error("spawn position arrived outside spawn wait");
`endif

endmodule

// ===== tb/sv/dla_walker_step_check.sv =====
// Checker for dla_walker_step: predicts the move deltas of each request and compares results.
module dla_walker_step_check
  import dla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  logic                  cmd_ready,
  input  logic                  command,
  input  logic [RAND_W-1:0]     rand_a,
  input  logic [RAND_W-1:0]     rand_b,
  input  logic                  res_valid,
  input  logic                  res_ready,
  input  logic [2:0]            event_res,
  input  logic                  dest_valid,
  input  logic [IDX_W-1:0]      dest_index,
  input  logic [IDX_W-1:0]      src_index,
  input  logic                  last_of_run,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    deltas_owed,
  output logic                  walker_live,
  output logic [COL_W-1:0]      walker_col,
  output logic [ROW_W-1:0]      walker_row
);

  localparam int unsigned CELLS = GRID_COLS * GRID_ROWS;

  // Predicted block state
  bit                grid [CELLS];
  int unsigned       cur_x;
  int unsigned       cur_y;
  logic [STEP_W-1:0] step_tally;
  bit                live;
  bit                perim_mode;
  logic [STEP_W-1:0] step_limit;
  res_t              delta_q [$];
  int                errs = 0;

  assign fail_count = errs;

  function automatic logic [IDX_W-1:0] cell_at(int unsigned x, int unsigned y);
    return IDX_W'(y * GRID_COLS + x);
  endfunction

  function automatic bit filled(int unsigned x, int unsigned y);
    return grid[y * GRID_COLS + x];
  endfunction

  function automatic res_t make_delta(event_t ev, logic ok, logic [IDX_W-1:0] dst,
                                      logic [IDX_W-1:0] src, logic fin);
    res_t d;
    d.ev         = ev;
    d.dest_valid = ok;
    d.dest_index = ok ? dst : '0;
    d.src_index  = src;
    d.last       = fin;
    return d;
  endfunction

  // Apply one request to the predicted grid and queue the deltas it causes
  function automatic void advance_walker(logic cmd, logic [RAND_W-1:0] ra,
                                         logic [RAND_W-1:0] rb);
    int unsigned      nx;
    int unsigned      ny;
    int unsigned      r;
    logic [IDX_W-1:0] from_cell;
    logic [IDX_W-1:0] to_cell;
    bit               off_grid;
    bit               touching;
    if (cmd == CMD_SPAWN) begin
      if (!perim_mode) begin
        case (dir_t'(ra[1:0]))
          DIR_UP: begin
            nx = rb % SPAN_X + 1;
            ny = 0;
          end
          DIR_RIGHT: begin
            nx = SPAN_X;
            ny = rb % SPAN_Y + 1;
          end
          DIR_DOWN: begin
            nx = rb % SPAN_X;
            ny = SPAN_Y;
          end
          default: begin
            nx = 0;
            ny = rb % SPAN_Y;
          end
        endcase
      end else begin
        // border taken side by side from (1,0): top and bottom left to right, sides top to bottom
        r = ra % PERIM;
        if (r < SPAN_X) begin
          nx = r + 1;
          ny = 0;
        end else if (r < SPAN_X + SPAN_Y) begin
          nx = SPAN_X;
          ny = r - SPAN_X + 1;
        end else if (r < 2 * SPAN_X + SPAN_Y) begin
          nx = r - (SPAN_X + SPAN_Y);
          ny = SPAN_Y;
        end else begin
          nx = 0;
          ny = r - (2 * SPAN_X + SPAN_Y);
        end
      end
      cur_x      = nx;
      cur_y      = ny;
      step_tally = '0;
      live       = 1'b1;
      to_cell    = cell_at(nx, ny);
      delta_q.push_back(make_delta(EV_SPAWN, 1'b1, to_cell, to_cell, 1'b1));
      return;
    end

    // step with no walker on the grid does nothing
    if (!live)
      return;

    if (step_tally != '1)
      step_tally++;

    nx       = cur_x;
    ny       = cur_y;
    off_grid = 1'b0;
    case (dir_t'(ra[1:0]))
      DIR_UP:    if (ny == 0) off_grid = 1'b1; else ny--;
      DIR_RIGHT: if (nx >= SPAN_X) off_grid = 1'b1; else nx++;
      DIR_DOWN:  if (ny >= SPAN_Y) off_grid = 1'b1; else ny++;
      default:   if (nx == 0) off_grid = 1'b1; else nx--;
    endcase
    from_cell = cell_at(cur_x, cur_y);

    // escape wins over sticking, sticking over timeout
    if (off_grid) begin
      live = 1'b0;
      delta_q.push_back(make_delta(EV_ESCAPE, 1'b0, '0, from_cell, 1'b1));
      return;
    end

    to_cell  = cell_at(nx, ny);
    touching = (ny > 0 && filled(nx, ny - 1)) || (ny < SPAN_Y && filled(nx, ny + 1)) ||
               (nx > 0 && filled(nx - 1, ny)) || (nx < SPAN_X && filled(nx + 1, ny));
    if (touching) begin
      grid[ny * GRID_COLS + nx] = 1'b1;
      live = 1'b0;
      delta_q.push_back(make_delta(EV_STUCK, 1'b1, to_cell, from_cell, 1'b1));
      return;
    end

    cur_x = nx;
    cur_y = ny;
    if (step_tally >= step_limit) begin
      live = 1'b0;
      delta_q.push_back(make_delta(EV_MOVE, 1'b1, to_cell, from_cell, 1'b0));
      delta_q.push_back(make_delta(EV_TIMEOUT, 1'b0, '0, to_cell, 1'b1));
    end else begin
      delta_q.push_back(make_delta(EV_MOVE, 1'b1, to_cell, from_cell, 1'b1));
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errs++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Track register writes, requests and results on each edge
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      foreach (grid[i])
        grid[i] = 1'b0;
      grid[SEED_Y * GRID_COLS + SEED_X] = 1'b1;
      cur_x      = 0;
      cur_y      = 0;
      step_tally = '0;
      live       = 1'b0;
      perim_mode = 1'b0;
      step_limit = MAX_STEPS_RESET;
      delta_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SPAWN_MODE: perim_mode = cfg_data[0];
          default:        step_limit = cfg_data;
        endcase
      end
      if (cmd_valid && cmd_ready)
        advance_walker(command, rand_a, rand_b);
      if (res_valid && res_ready) begin
        if (delta_q.size() == 0) begin
          errs++;
          $error("result with nothing pending: event_res %0d src_index %0d",
                 event_res, src_index);
        end else begin
          want = delta_q.pop_front();
          check_field("event_res", 32'(want.ev), 32'(event_res));
          check_field("dest_valid", 32'(want.dest_valid), 32'(dest_valid));
          check_field("dest_index", 32'(want.dest_index), 32'(dest_index));
          check_field("src_index", 32'(want.src_index), 32'(src_index));
          check_field("last_of_run", 32'(want.last), 32'(last_of_run));
        end
      end
    end
    deltas_owed <= delta_q.size();
    walker_live <= live;
    walker_col  <= COL_W'(cur_x);
    walker_row  <= ROW_W'(cur_y);
  end

endmodule

// ===== tb/sv/dla_walker_step_test.sv =====
// Testbench top for dla_walker_step: request stimulus, result stalls, register writes, verdict.
module dla_walker_step_test;
  import dla_pkg::*;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  cmd_valid  = 1'b0;
  logic                  cmd_ready;
  logic                  command    = 1'b0;
  logic [RAND_W-1:0]     rand_a     = '0;
  logic [RAND_W-1:0]     rand_b     = '0;
  logic                  res_valid;
  logic                  res_ready  = 1'b0;
  logic [2:0]            event_res;
  logic                  dest_valid;
  logic [IDX_W-1:0]      dest_index;
  logic [IDX_W-1:0]      src_index;
  logic                  last_of_run;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int                    fail_count;
  int                    deltas_owed;
  logic                  walker_live;
  logic [COL_W-1:0]      walker_col;
  logic [ROW_W-1:0]      walker_row;

  bit                    idle_on    = 1'b1;
  bit                    jam_done   = 1'b0;
  int                    sent       = 0;
  int                    hold_left  = 0;

  always #2 clk = ~clk;

  dla_walker_step u_dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .command     (command),
    .rand_a      (rand_a),
    .rand_b      (rand_b),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .event_res   (event_res),
    .dest_valid  (dest_valid),
    .dest_index  (dest_index),
    .src_index   (src_index),
    .last_of_run (last_of_run),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  dla_walker_step_check u_check (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .command     (command),
    .rand_a      (rand_a),
    .rand_b      (rand_b),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .event_res   (event_res),
    .dest_valid  (dest_valid),
    .dest_index  (dest_index),
    .src_index   (src_index),
    .last_of_run (last_of_run),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .deltas_owed (deltas_owed),
    .walker_live (walker_live),
    .walker_col  (walker_col),
    .walker_row  (walker_row)
  );

  // Result side: short random stalls, and one long hold so requests back up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!jam_done && sent >= 200) begin
      jam_done  <= 1'b1;
      res_ready <= 1'b0;
      hold_left <= 99;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      res_ready <= 1'b0;
      hold_left <= $urandom_range(0, 2);
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Offer one request, maybe after a short gap, and wait until it is taken
  task automatic send_req(input cmd_t op, input logic [RAND_W-1:0] a,
                          input logic [RAND_W-1:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command   <= op;
    rand_a    <= a;
    rand_b    <= b;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sent <= sent + 1;
  endtask

  // Wait for every predicted delta, then let an ignored step finish
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (deltas_owed != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_regs(input logic mode, input logic [CFG_DATA_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SPAWN_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= REG_MAX_STEPS;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly head for the seed so walkers reach the cluster; sometimes wander
  function automatic dir_t toward_seed();
    int dx;
    int dy;
    dx = SEED_X - int'(walker_col);
    dy = SEED_Y - int'(walker_row);
    if ($urandom_range(0, 19) == 0)
      return dir_t'($urandom_range(0, 3));
    if (dx * dx > dy * dy || (dx * dx == dy * dy && $urandom_range(0, 1) == 1))
      return (dx > 0) ? DIR_RIGHT : DIR_LEFT;
    return (dy > 0) ? DIR_DOWN : DIR_UP;
  endfunction

  task automatic run_walks(input int count, input bit guided, input bit perim);
    logic [RAND_W-1:0] a;
    logic [RAND_W-1:0] b;
    bit                spawned;
    int                n;
    // the live hint lags one request, so never spawn twice on its account
    spawned = 1'b0;
    for (n = 0; n < count; n++) begin
      a = $urandom;
      b = $urandom;
      if ((!walker_live && !spawned) || $urandom_range(0, 59) == 0) begin
        if (guided && $urandom_range(0, 4) != 0) begin
          // start near the middle of the top or bottom edge
          if (perim) begin
            a = $urandom_range(250, 350);
            if ($urandom_range(0, 1) == 1)
              a = a + SPAN_X + SPAN_Y;
          end else begin
            a[1:0] = ($urandom_range(0, 1) == 1) ? DIR_UP : DIR_DOWN;
            b = $urandom_range(250, 350);
          end
        end
        send_req(CMD_SPAWN, a, b);
        spawned = 1'b1;
      end else begin
        if (guided)
          a[1:0] = toward_seed();
        send_req(CMD_STEP, a, b);
        spawned = 1'b0;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // occupancy sweep after reset
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);

    // side spawns, escapes off each edge, timeout, ignored steps
    set_regs(1'b0, 16'd3);
    send_req(CMD_STEP, RAND_W'(DIR_DOWN), '0);
    send_req(CMD_SPAWN, RAND_W'(DIR_UP), '0);
    send_req(CMD_STEP, RAND_W'(DIR_UP), '1);
    send_req(CMD_SPAWN, RAND_W'(DIR_RIGHT), '1);
    send_req(CMD_STEP, RAND_W'(DIR_RIGHT), 32'h5555_5555);
    send_req(CMD_SPAWN, RAND_W'(DIR_DOWN), 32'd598);
    send_req(CMD_STEP, RAND_W'(DIR_DOWN), '0);
    send_req(CMD_SPAWN, '1, 32'd398);
    send_req(CMD_STEP, '1, '0);
    send_req(CMD_SPAWN, RAND_W'(DIR_UP), 32'd299);
    send_req(CMD_STEP, RAND_W'(DIR_DOWN), '0);
    send_req(CMD_STEP, RAND_W'(DIR_RIGHT), '0);
    send_req(CMD_STEP, RAND_W'(DIR_DOWN), '0);
    send_req(CMD_STEP, RAND_W'(DIR_UP), '0);
    send_req(CMD_SPAWN, RAND_W'(DIR_DOWN), $urandom);
    // respawn replaces the live walker
    send_req(CMD_SPAWN, RAND_W'(DIR_UP), '0);
    send_req(CMD_STEP, RAND_W'(DIR_LEFT), '0);
    send_req(CMD_STEP, RAND_W'(DIR_LEFT), '0);
    drain();

    // perimeter spawns at the wrap points, one-step limit
    set_regs(1'b1, 16'd1);
    send_req(CMD_SPAWN, '0, '0);
    send_req(CMD_SPAWN, '1, '0);
    send_req(CMD_SPAWN, RAND_W'(PERIM - 1), '0);
    send_req(CMD_SPAWN, RAND_W'(SPAN_X), '0);
    send_req(CMD_STEP, 32'hFFFF_FFFE, '1);
    drain();

    // a zero limit behaves as one
    set_regs(1'b1, 16'd0);
    send_req(CMD_SPAWN, RAND_W'(SPAN_X + SPAN_Y), '0);
    send_req(CMD_STEP, RAND_W'(DIR_UP), '0);
    drain();

    // random walks across several settings
    set_regs(1'b1, 16'hFFFF);
    run_walks(450, 1'b1, 1'b1);
    drain();
    set_regs(1'b0, 16'd20);
    run_walks(250, 1'b0, 1'b0);
    drain();
    set_regs(1'b0, 16'd2000);
    run_walks(450, 1'b1, 1'b0);
    drain();
    set_regs(1'b1, 16'd7);
    run_walks(150, 1'b0, 1'b1);
    drain();

    // last stretch at full rate on both sides
    idle_on <= 1'b0;
    set_regs(1'b1, 16'd10000);
    run_walks(375, 1'b1, 1'b1);
    drain();

    if (fail_count == 0)
      $display("dla_walker_step_test passed");
    else
      $display("dla_walker_step_test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #1600000;
    $display("dla_walker_step_test failed");
    $finish;
  end

endmodule
